// ----- rtl/core/oriented_box_measure_macros.svh -----
// Assertion helpers shared by the block's RTL.
`ifndef ORIENTED_BOX_MEASURE_MACROS_SVH
`define ORIENTED_BOX_MEASURE_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define OBM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks the cycle after reset is seen low.
`define OBM_ASSERT_AFTER_RESET(lbl, clk, rstn, cons, msg) \
    lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/obm_pkg.sv -----
package obm_pkg;

    localparam int COORD_W     = 18;
    localparam int LEN_W       = 19;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int CSUM_W      = COORD_W + 2;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int RAD_W       = 2 * LEN_W;
    localparam int CORNERS     = 4;
    localparam int LANES       = 3;
    localparam int ROOT_STAGES = LEN_W;

    // lane assignment of the three lengths
    localparam int LANE_H = 0;
    localparam int LANE_W = 1;
    localparam int LANE_D = 2;

    localparam int S_DATA_W   = ((2 * CORNERS * COORD_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + 3 * LEN_W + 6 * COORD_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic [LANES-1:0][RAD_W-1:0] rad_vec_t;
    typedef logic [LANES-1:0][LEN_W-1:0] len_vec_t;

    // values that ride alongside the square-root pipe
    typedef struct packed {
        logic   mode;
        logic   start;
        coord_t center_x;
        coord_t center_y;
        coord_t left_mid_x;
        coord_t left_mid_y;
        coord_t right_mid_x;
        coord_t right_mid_y;
    } side_t;

endpackage

// ----- rtl/core/obm_root_pipe.sv -----
// Three parallel integer square roots, one result bit per stage.
module obm_root_pipe
    import obm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  rad_vec_t in_rad,
    input  side_t    in_side,
    output logic     out_valid,
    input  logic     out_ready,
    output len_vec_t out_root,
    output side_t    out_side
);

    logic                          valid_reg [ROOT_STAGES];
    logic [LANES-1:0][LEN_W:0]     rem_reg   [ROOT_STAGES];
    len_vec_t                      root_reg  [ROOT_STAGES];
    rad_vec_t                      rad_reg   [ROOT_STAGES];
    side_t                         side_reg  [ROOT_STAGES];
    logic [ROOT_STAGES:0]          stage_en;

    // a stage moves when empty or when the one ahead moves
    always_comb begin
        stage_en[ROOT_STAGES] = out_ready;
        for (int s = ROOT_STAGES - 1; s >= 0; s--) begin
            stage_en[s] = !valid_reg[s] || stage_en[s+1];
        end
    end

    genvar k, l;
    generate
        for (k = 0; k < ROOT_STAGES; k++) begin : g_stage
            logic                      valid_in;
            logic [LANES-1:0][LEN_W:0] rem_in;
            len_vec_t                  root_in;
            rad_vec_t                  rad_in;
            side_t                     side_in;
            logic [LANES-1:0][LEN_W:0] rem_next;
            len_vec_t                  root_next;
            rad_vec_t                  rad_next;

            if (k == 0) begin : g_first
                assign valid_in = in_valid;
                assign rem_in   = '0;
                assign root_in  = '0;
                assign rad_in   = in_rad;
                assign side_in  = in_side;
            end else begin : g_rest
                assign valid_in = valid_reg[k-1];
                assign rem_in   = rem_reg[k-1];
                assign root_in  = root_reg[k-1];
                assign rad_in   = rad_reg[k-1];
                assign side_in  = side_reg[k-1];
            end

            for (l = 0; l < LANES; l++) begin : g_lane
                logic [LEN_W+2:0] cur;
                logic [LEN_W+2:0] trial;
                logic [LEN_W+2:0] diff;
                logic             fits;

                always_comb begin
                    // bring down the next two radicand bits
                    cur          = {rem_in[l], rad_in[l][RAD_W-1 -: 2]};
                    trial        = {1'b0, root_in[l], 2'b01};
                    diff         = cur - trial;
                    fits         = (cur >= trial);
                    rem_next[l]  = fits ? diff[LEN_W:0] : cur[LEN_W:0];
                    root_next[l] = {root_in[l][LEN_W-2:0], fits};
                    rad_next[l]  = {rad_in[l][RAD_W-3:0], 2'b00};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (stage_en[k]) begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (stage_en[k]) begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    rad_reg[k]  <= rad_next;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[ROOT_STAGES-1];
    assign out_root  = root_reg[ROOT_STAGES-1];
    assign out_side  = side_reg[ROOT_STAGES-1];

endmodule

// ----- rtl/core/oriented_box_measure.sv -----
// Oriented box measurement.
// Input channel s_*: one word per box, the four clockwise corners in signed
// Q13.4 plus the mode flag in tuser (0 = unrectified, width forced >= height).
// Output channel m_*: one word per box: start corner, height, width and
// diagonal (floor square roots, unsigned Q15.4), center and the left and
// right side midpoints (floored means, signed Q13.4).
// Pipeline: 4 front stages (corner ordering, differences and sums, squares,
// radicand add), 19 square-root stages that settle one result bit each,
// and the output register.
// Throughput: one box per cycle; every stage is a register with its own
// valid bit, so a new word is taken each cycle the pipe is not full.
// Reset (aresetn low, synchronous) clears all valid bits; words in flight
// are dropped. When m_tready is low the output word holds, stages behind
// it fill bubbles first, and s_tready drops only once every stage is full.
`include "oriented_box_measure_macros.svh"

module oriented_box_measure
    import obm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y
    input  logic [S_DATA_W-1:0] s_tdata,
    // mode
    input  logic [0:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // start_corner, box_height, box_width, box_diagonal, center_x, center_y,
    // left_mid_x, left_mid_y, right_mid_x, right_mid_y, zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    logic a_en, b_en, c_en, d_en, o_en;
    logic root_in_ready;

    // stage A: order corners
    coord_t cx [CORNERS];
    coord_t cy [CORNERS];
    coord_t a_px_next [CORNERS];
    coord_t a_py_next [CORNERS];
    logic   a_start_next;
    logic   a_valid_reg;
    coord_t a_px_reg [CORNERS];
    coord_t a_py_reg [CORNERS];
    logic   a_start_reg;
    logic   a_mode_reg;

    always_comb begin
        for (int j = 0; j < CORNERS; j++) begin
            cx[j] = s_tdata[2 * j * COORD_W +: COORD_W];
            cy[j] = s_tdata[(2 * j + 1) * COORD_W +: COORD_W];
        end
        a_start_next = (cx[0] > cx[2]);
        for (int j = 0; j < CORNERS; j++) begin
            a_px_next[j] = a_start_next ? cx[2'(j + 1)] : cx[2'(j)];
            a_py_next[j] = a_start_next ? cy[2'(j + 1)] : cy[2'(j)];
        end
    end

    // stage B: differences and pair sums
    diff_t b_dx_next [LANES];
    diff_t b_dy_next [LANES];
    diff_t b_dx_reg  [LANES];
    diff_t b_dy_reg  [LANES];
    diff_t b_sx01_reg, b_sx23_reg, b_sy01_reg, b_sy23_reg;
    logic  b_valid_reg, b_start_reg, b_mode_reg;

    always_comb begin
        b_dx_next[LANE_H] = DIFF_W'(a_px_reg[0]) - DIFF_W'(a_px_reg[1]);
        b_dy_next[LANE_H] = DIFF_W'(a_py_reg[0]) - DIFF_W'(a_py_reg[1]);
        b_dx_next[LANE_W] = DIFF_W'(a_px_reg[2]) - DIFF_W'(a_px_reg[1]);
        b_dy_next[LANE_W] = DIFF_W'(a_py_reg[2]) - DIFF_W'(a_py_reg[1]);
        b_dx_next[LANE_D] = DIFF_W'(a_px_reg[2]) - DIFF_W'(a_px_reg[0]);
        b_dy_next[LANE_D] = DIFF_W'(a_py_reg[2]) - DIFF_W'(a_py_reg[0]);
    end

    // stage C: squares, center and midpoints
    logic signed [2*DIFF_W-1:0] prod_x [LANES];
    logic signed [2*DIFF_W-1:0] prod_y [LANES];
    logic signed [CSUM_W-1:0]   c_csx_next, c_csy_next;
    side_t                      c_side_next;
    logic [SQ_W-1:0]            c_sqx_reg [LANES];
    logic [SQ_W-1:0]            c_sqy_reg [LANES];
    side_t                      c_side_reg;
    logic                       c_valid_reg;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            prod_x[j] = b_dx_reg[j] * b_dx_reg[j];
            prod_y[j] = b_dy_reg[j] * b_dy_reg[j];
        end
        c_csx_next = CSUM_W'(b_sx01_reg) + CSUM_W'(b_sx23_reg);
        c_csy_next = CSUM_W'(b_sy01_reg) + CSUM_W'(b_sy23_reg);
        // dropping low bits of a two's complement sum floors the mean
        c_side_next.mode        = b_mode_reg;
        c_side_next.start       = b_start_reg;
        c_side_next.center_x    = c_csx_next[COORD_W+1:2];
        c_side_next.center_y    = c_csy_next[COORD_W+1:2];
        c_side_next.left_mid_x  = b_sx01_reg[COORD_W:1];
        c_side_next.left_mid_y  = b_sy01_reg[COORD_W:1];
        c_side_next.right_mid_x = b_sx23_reg[COORD_W:1];
        c_side_next.right_mid_y = b_sy23_reg[COORD_W:1];
    end

    // stage D: radicands
    rad_vec_t d_rad_next;
    rad_vec_t d_rad_reg;
    side_t    d_side_reg;
    logic     d_valid_reg;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            d_rad_next[j] = RAD_W'(c_sqx_reg[j]) + RAD_W'(c_sqy_reg[j]);
        end
    end

    // square roots
    logic     r_valid;
    len_vec_t r_root;
    side_t    r_side;

    obm_root_pipe u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid_reg),
        .in_ready  (root_in_ready),
        .in_rad    (d_rad_reg),
        .in_side   (d_side_reg),
        .out_valid (r_valid),
        .out_ready (o_en),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    // output register with unrectified swap
    len_t  o_h_next, o_w_next;
    logic  o_valid_reg;
    len_t  o_h_reg, o_w_reg, o_d_reg;
    side_t o_side_reg;

    always_comb begin
        if (!r_side.mode && (r_root[LANE_W] < r_root[LANE_H])) begin
            o_h_next = r_root[LANE_W];
            o_w_next = r_root[LANE_H];
        end else begin
            o_h_next = r_root[LANE_H];
            o_w_next = r_root[LANE_W];
        end
    end

    // stall chain: a stage moves when empty or when the one ahead moves
    assign o_en     = !o_valid_reg || m_tready;
    assign d_en     = !d_valid_reg || root_in_ready;
    assign c_en     = !c_valid_reg || d_en;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign s_tready = a_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (a_en) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_en) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_en) begin
                d_valid_reg <= c_valid_reg;
            end
            if (o_en) begin
                o_valid_reg <= r_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_px_reg    <= a_px_next;
            a_py_reg    <= a_py_next;
            a_start_reg <= a_start_next;
            a_mode_reg  <= s_tuser[0];
        end
        if (b_en) begin
            b_dx_reg    <= b_dx_next;
            b_dy_reg    <= b_dy_next;
            b_sx01_reg  <= DIFF_W'(a_px_reg[0]) + DIFF_W'(a_px_reg[1]);
            b_sx23_reg  <= DIFF_W'(a_px_reg[2]) + DIFF_W'(a_px_reg[3]);
            b_sy01_reg  <= DIFF_W'(a_py_reg[0]) + DIFF_W'(a_py_reg[1]);
            b_sy23_reg  <= DIFF_W'(a_py_reg[2]) + DIFF_W'(a_py_reg[3]);
            b_start_reg <= a_start_reg;
            b_mode_reg  <= a_mode_reg;
        end
        if (c_en) begin
            for (int j = 0; j < LANES; j++) begin
                c_sqx_reg[j] <= prod_x[j][SQ_W-1:0];
                c_sqy_reg[j] <= prod_y[j][SQ_W-1:0];
            end
            c_side_reg <= c_side_next;
        end
        if (d_en) begin
            d_rad_reg  <= d_rad_next;
            d_side_reg <= c_side_reg;
        end
        if (o_en) begin
            o_h_reg    <= o_h_next;
            o_w_reg    <= o_w_next;
            o_d_reg    <= r_root[LANE_D];
            o_side_reg <= r_side;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}},
                       o_side_reg.right_mid_y, o_side_reg.right_mid_x,
                       o_side_reg.left_mid_y, o_side_reg.left_mid_x,
                       o_side_reg.center_y, o_side_reg.center_x,
                       o_d_reg, o_w_reg, o_h_reg, o_side_reg.start};

    `OBM_ASSERT_IMPLY(a_order_chk, aclk, aresetn, a_valid_reg && !a_start_reg, a_px_reg[0] <= a_px_reg[2], "kept order but corner 0 lies right of corner 2")
    `OBM_ASSERT_IMPLY(swap_chk, aclk, aresetn, o_valid_reg && !o_side_reg.mode, o_w_reg >= o_h_reg, "unrectified word has width below height")
    `OBM_ASSERT_IMPLY(full_chk, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled while the pipe has a free stage")
    `OBM_ASSERT_AFTER_RESET(reset_chk, aclk, aresetn, !m_tvalid, "output word valid right after reset")

endmodule
